FILE: hw/rtl/cba_pkg.sv
package cba_pkg;

  // Placement rules held in the fit_policy register
  localparam logic [1:0] FIT_FF = 2'd0;  // first fit
  localparam logic [1:0] FIT_WF = 2'd1;  // worst fit, largest hole
  localparam logic [1:0] FIT_BF = 2'd2;  // best fit, smallest hole that fits

  // Control from the sequencer to the hole scanner
  typedef struct packed {
    logic clear;  // start a new scan
    logic valid;  // one map entry arrives this cycle
    logic free;   // that entry is unowned
    logic flush;  // past the last entry: close the open run
  } scan_ctrl_t;

endpackage

FILE: hw/rtl/cba_hole_scan.sv
module cba_hole_scan #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cba_pkg::scan_ctrl_t             ctrl_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0]   idx_i,
  input  logic [8:0]                      size_i,
  input  logic [1:0]                      policy_i,
  output logic                            found_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]   best_start_o
);
  import cba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = AW + 1;
  localparam int LW = (CW > 9) ? CW : 9;

  logic [AW-1:0] run_start_q, run_start_d;
  logic [CW-1:0] run_len_q, run_len_d;
  logic [AW-1:0] best_start_q, best_start_d;
  logic [CW-1:0] best_len_q, best_len_d;
  logic          found_q, found_d;
  logic          close_run;
  logic          fits;
  logic          take;

  assign close_run = (ctrl_i.valid && !ctrl_i.free) || ctrl_i.flush;
  assign fits      = (run_len_q != '0) && (LW'(run_len_q) >= LW'(size_i));

  always_comb begin
    case (policy_i)
      FIT_WF:  take = !found_q || (run_len_q > best_len_q);
      FIT_BF:  take = !found_q || (run_len_q < best_len_q);
      default: take = !found_q;
    endcase
  end

  always_comb begin
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    found_d      = found_q;
    if (ctrl_i.clear) begin
      run_len_d = '0;
      found_d   = 1'b0;
    end else if (ctrl_i.valid && ctrl_i.free) begin
      if (run_len_q == '0) begin
        run_start_d = idx_i;
      end
      run_len_d = run_len_q + 1'b1;
    end else if (close_run) begin
      // Hole ends here: keep it if it fits and beats the current pick
      if (fits && take) begin
        found_d      = 1'b1;
        best_start_d = run_start_q;
        best_len_d   = run_len_q;
      end
      run_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= '0;
      found_q   <= 1'b0;
    end else begin
      run_len_q <= run_len_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_start_q  <= run_start_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
  end

  assign found_o      = found_q;
  assign best_start_o = best_start_q;

endmodule

FILE: hw/rtl/contiguous_block_allocator.sv
// Contiguous block allocator. A map of NUM_BLOCKS entries holds the owner id of
// each block (0 = free). An allocate transfer (mode 0) places a run of
// request_size blocks in a free hole chosen by fit_policy (first, worst or best
// fit, ties to the lowest start) and returns the start block and the new id; a
// release transfer (mode 1) frees every block owned by release_id. The map sits
// in one synchronous memory read one entry per cycle, so every request but a
// zero-size allocation walks the whole map; a successful allocation then writes
// its request_size blocks in turn, and a zero-size one fails at once. After
// reset the block runs a clearing pass over the map with in_stall_o high.
// fit_policy may be written at any time the block is idle; cfg_ready_o stays
// high. A finished result waits in the output register while the next request
// is taken.
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS = 256,
  parameter int ID_WIDTH   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [8:0]  request_size_i,
  input  logic [15:0] release_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [7:0]  start_block_o,
  output logic [15:0] owner_id_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_fit_policy_i
);
  import cba_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int SW = (AW > 8) ? AW : 8;
  localparam int IW = (ID_WIDTH > 16) ? ID_WIDTH : 16;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_CLOSE,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        cnt_q;
  logic                 mode_q;
  logic [8:0]           size_q;
  logic [ID_WIDTH-1:0]  rel_q;
  logic [AW-1:0]        wa_q;
  logic [8:0]           rem_q;
  logic [ID_WIDTH-1:0]  next_id_q, next_id_d;
  logic [1:0]           policy_q;
  logic                 res_ok_q;
  logic [AW-1:0]        res_start_q;
  logic [ID_WIDTH-1:0]  res_id_q;
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [AW-1:0]        out_start_q;
  logic [ID_WIDTH-1:0]  out_id_q;

  // Block map
  logic [ID_WIDTH-1:0]  mem_q [NUM_BLOCKS];
  logic [ID_WIDTH-1:0]  rd_data_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 rd_vld_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ID_WIDTH-1:0]  mem_wdata;
  logic                 rel_hit;

  scan_ctrl_t           scan_ctrl;
  logic                 scan_found;
  logic [AW-1:0]        scan_start;

  logic                 in_xfer;
  logic [IW-1:0]        rel_ext;
  logic [SW-1:0]        start_ext;
  logic [IW-1:0]        id_ext;

  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rel_ext     = IW'(release_id_i);

  assign rel_hit = rd_vld_q && mode_q && (rd_data_q == rel_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wa_q;
        mem_wdata = res_id_q;
      end
      default: begin
        // Drop matching entries in the cycle after they are read
        mem_we    = rel_hit;
        mem_waddr = rd_idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_SCAN) begin
      rd_data_q <= mem_q[cnt_q];
    end
    rd_idx_q <= cnt_q;
  end

  assign scan_ctrl.clear = in_xfer;
  assign scan_ctrl.valid = rd_vld_q && !mode_q;
  assign scan_ctrl.free  = (rd_data_q == '0);
  assign scan_ctrl.flush = (state_q == ST_CLOSE) && !mode_q;

  cba_hole_scan #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_hole_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .idx_i        (rd_idx_q),
    .size_i       (size_q),
    .policy_i     (policy_q),
    .found_o      (scan_found),
    .best_start_o (scan_start)
  );

  // Owner ids count modulo 2^ID_WIDTH and skip zero
  always_comb begin
    next_id_d = next_id_q + 1'b1;
    if (next_id_d == '0) begin
      next_id_d = ID_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      next_id_q   <= ID_WIDTH'(1);
      policy_q    <= FIT_FF;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      if (cfg_valid_i) begin
        policy_q <= cfg_fit_policy_i;
      end
      // Load a finished result, or drop the one just transferred
      if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            mode_q      <= mode_i;
            size_q      <= request_size_i;
            rel_q       <= rel_ext[ID_WIDTH-1:0];
            cnt_q       <= '0;
            res_ok_q    <= 1'b0;
            res_start_q <= '0;
            res_id_q    <= '0;
            if (!mode_i && (request_size_i == '0)) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_ADDR) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_CLOSE;
        end
        ST_CLOSE: begin
          if (mode_q) begin
            res_ok_q <= 1'b1;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (scan_found) begin
            wa_q        <= scan_start;
            rem_q       <= size_q;
            res_ok_q    <= 1'b1;
            res_start_q <= scan_start;
            res_id_q    <= next_id_q;
            state_q     <= ST_WRITE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_WRITE: begin
          wa_q  <= wa_q + 1'b1;
          rem_q <= rem_q - 1'b1;
          if (rem_q == 9'd1) begin
            next_id_q <= next_id_d;
            state_q   <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_ok_q    <= res_ok_q;
            out_start_q <= res_start_q;
            out_id_q    <= res_id_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign start_ext     = SW'(out_start_q);
  assign id_ext        = IW'(out_id_q);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign start_block_o = start_ext[7:0];
  assign owner_id_o    = id_ext[15:0];

endmodule

FILE: hw/rtl/cba_port_check.sv
module cba_port_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        ok_o,
  input logic [7:0]  start_block_o,
  input logic [15:0] owner_id_o
);

  // A stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o)
      && $stable(start_block_o) && $stable(owner_id_o))
    else $error("result changed while stalled");

  // A failed allocation reports no start block and no id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (start_block_o == 8'd0) && (owner_id_o == 16'd0))
    else $error("failed allocation with nonzero fields");

  // One request at a time: busy right after a transfer is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind contiguous_block_allocator cba_port_check u_port_check (.*);
